### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the peak finder.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/glpf_pkg.sv
`default_nettype none

package glpf_pkg;

	// Field widths of the result request.
	localparam int ROW_BITS = 10;
	localparam int COL_BITS = 6;

	// Configuration register widths and reset values.
	localparam int GC_BITS = 7;
	localparam int GR_BITS = 10;
	localparam logic [GC_BITS-1:0] GRID_COLUMNS_RESET = 7'd64;
	localparam logic [GR_BITS-1:0] GRID_ROWS_RESET    = 10'd2;

	// Register port geometry.
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	// Register indexes, taken from address bit 2.
	localparam logic [0:0] REG_GRID_COLUMNS = 1'b0;
	localparam logic [0:0] REG_GRID_ROWS    = 1'b1;

	// Pending results of one pixel, delivered from the lowest bit upwards.
	typedef struct packed {
		logic fin;    // final pixel of the frame judges itself
		logic left;   // last-row pixel one column to the left
		logic above;  // pixel of the row above
	} res_mask_t;

endpackage

`default_nettype wire

### hdl/glpf_line_buf.sv
`default_nettype none

module glpf_line_buf #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	input  wire logic [AW-1:0]    rd_addr_next,
	output logic      [WIDTH-1:0] prev_cur,
	output logic      [WIDTH-1:0] prev_next,
	output logic      [WIDTH-1:0] older_cur,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_prev,
	input  wire logic [WIDTH-1:0] wr_older
);

	logic [WIDTH-1:0] prev_mem  [DEPTH];
	logic [WIDTH-1:0] older_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_mem[wr_addr]  <= wr_prev;
			older_mem[wr_addr] <= wr_older;
		end
	end

	// A read that meets a write to the same entry in the same cycle sees the new data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			prev_cur  <= (wr_en && wr_addr == rd_addr) ? wr_prev : prev_mem[rd_addr];
			prev_next <= (wr_en && wr_addr == rd_addr_next) ? wr_prev : prev_mem[rd_addr_next];
			older_cur <= (wr_en && wr_addr == rd_addr) ? wr_older : older_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/grid_local_peak_finder_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Streaming 4-neighbour local-maximum finder. Pixels arrive in raster order on the pixel
// request channel and the unit reports the row and column of every pixel that is greater than
// or equal to each of its neighbours inside the grid, with border and corner pixels compared
// only against the neighbours that exist. The unit takes one pixel per clock unless held
// off: a pixel is registered together with the line-store reads of its column, the
// comparisons are made in the following cycle, and the result requests are then presented
// from an output register. A pixel decides the pixel directly above it; on the last row it
// also decides its left neighbour, and the final pixel of the frame decides itself, so a
// pixel yields between zero and three result requests. Results leave one at a time, so the
// input is held off only while a pixel with more than one result is still being drained
// (only on the last row of the frame) or while the sink stalls. The first result of a pixel
// appears when it moves from stage 1 into the output register. Results come in raster order,
// except that the last two rows interleave; last_of_run marks the final result of each pixel.
// The two line stores are single-write memories read on every accepted pixel, need no
// clearing after reset, and the row and column counters wrap to zero after the final pixel.
// grid_columns and grid_rows are written through the register port at byte addresses 0 and 4
// and must only be changed while the unit is idle; values below two act as two and a column
// count above MAX_COLS acts as MAX_COLS.
module grid_local_peak_finder_unit #(
	parameter int MAX_COLS   = 64,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Register port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [glpf_pkg::PADDR_BITS-1:0]       paddr,
	input  wire logic [glpf_pkg::PDATA_BITS-1:0]       pwdata,
	output logic      [glpf_pkg::PDATA_BITS-1:0]       prdata,
	output logic                                       pready,
	// Pixel requests
	input  wire logic                                  pixel_valid,
	output logic                                       pixel_ready,
	input  wire logic signed [PIXEL_BITS-1:0]          pixel_value,
	// Peak requests
	output logic                                       peak_valid,
	input  wire logic                                  peak_ready,
	output logic      [glpf_pkg::ROW_BITS-1:0]         peak_row,
	output logic      [glpf_pkg::COL_BITS-1:0]         peak_col,
	output logic                                       last_of_run
);

	import glpf_pkg::*;

	// Column index width, width able to hold MAX_COLS itself, and a compare width that also
	// holds the raw column register.
	localparam int CIDX  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int CMP_W = (CNT_W > GC_BITS) ? CNT_W : GC_BITS;
	localparam int RW    = GR_BITS + 1;

	// ---------------------------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------------------------
	logic [GC_BITS-1:0] grid_columns_q;
	logic [GR_BITS-1:0] grid_rows_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_COLUMNS_RESET;
			grid_rows_q    <= GRID_ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_GRID_COLUMNS: grid_columns_q <= pwdata[GC_BITS-1:0];
				REG_GRID_ROWS:    grid_rows_q    <= pwdata[GR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GRID_COLUMNS: prdata = PDATA_BITS'(grid_columns_q);
			REG_GRID_ROWS:    prdata = PDATA_BITS'(grid_rows_q);
			default:          prdata = '0;
		endcase
	end

	// Effective grid size after clamping.
	logic [CMP_W-1:0] gc_ext;
	logic [CMP_W-1:0] cols_eff;
	logic [RW-1:0]    gr_ext;
	logic [RW-1:0]    rows_eff;

	assign gc_ext   = CMP_W'(grid_columns_q);
	assign cols_eff = (gc_ext < CMP_W'(2)) ? CMP_W'(2) :
		(gc_ext > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : gc_ext;
	assign gr_ext   = RW'(grid_rows_q);
	assign rows_eff = (gr_ext < RW'(2)) ? RW'(2) : gr_ext;

	// ---------------------------------------------------------------------------------------
	// Position counters, advanced on every accepted pixel
	// ---------------------------------------------------------------------------------------
	logic [ROW_BITS-1:0] row_q;
	logic [CIDX-1:0]     col_q;
	logic                acc;
	logic                lastc_in;
	logic                lastr_in;
	logic [CIDX-1:0]     col_next_addr;

	assign acc      = pixel_valid && pixel_ready;
	assign lastc_in = (CMP_W'(col_q) + CMP_W'(1)) >= cols_eff;
	assign lastr_in = (RW'(row_q) + RW'(1)) >= rows_eff;

	// The right-hand read is only used when the column is not the last one; it is kept
	// inside the store at the top column.
	assign col_next_addr = (CNT_W'(col_q) == CNT_W'(MAX_COLS - 1)) ? '0 : col_q + CIDX'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (lastc_in) begin
				col_q <= '0;
				row_q <= lastr_in ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CIDX'(1);
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Stage 1: the accepted pixel and the line-store reads of its column
	// ---------------------------------------------------------------------------------------
	logic                         s1_valid_q;
	logic                         s1_adv;
	logic signed [PIXEL_BITS-1:0] v_s1;
	logic [ROW_BITS-1:0]          r_s1;
	logic [CIDX-1:0]              c_s1;
	logic                         lastc_s1;
	logic                         lastr_s1;
	logic signed [PIXEL_BITS-1:0] up_s1;      // row above, same column
	logic signed [PIXEL_BITS-1:0] upright_s1; // row above, next column
	logic signed [PIXEL_BITS-1:0] up2_s1;     // two rows above, same column

	// Horizontal neighbours held across pixels.
	logic signed [PIXEL_BITS-1:0] upleft_q;   // row above, previous column
	logic signed [PIXEL_BITS-1:0] left_q;     // current row, previous column
	logic signed [PIXEL_BITS-1:0] left2_q;    // current row, two columns back

	glpf_line_buf #(
		.DEPTH (MAX_COLS),
		.WIDTH (PIXEL_BITS),
		.AW    (CIDX)
	) u_line_buf (
		.clk          (clk),
		.rd_en        (acc),
		.rd_addr      (col_q),
		.rd_addr_next (col_next_addr),
		.prev_cur     (up_s1),
		.prev_next    (upright_s1),
		.older_cur    (up2_s1),
		.wr_en        (s1_adv),
		.wr_addr      (c_s1),
		.wr_prev      (v_s1),
		.wr_older     (up_s1)
	);

	assign pixel_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			v_s1     <= pixel_value;
			r_s1     <= row_q;
			c_s1     <= col_q;
			lastc_s1 <= lastc_in;
			lastr_s1 <= lastr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (s1_adv) begin
			left_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			upleft_q <= up_s1;
			left2_q  <= left_q;
		end
	end

	// Neighbour tests for the three candidates.
	res_mask_t hit;
	logic      c_ge1;
	logic      c_ge2;

	assign c_ge1 = (c_s1 != '0);
	assign c_ge2 = (CNT_W'(c_s1) >= CNT_W'(2));

	always_comb begin
		hit.above = (r_s1 != '0) && (up_s1 >= v_s1)
			&& ((r_s1 < ROW_BITS'(2)) || (up_s1 >= up2_s1))
			&& (!c_ge1 || (up_s1 >= upleft_q))
			&& (lastc_s1 || (up_s1 >= upright_s1));
		hit.left  = lastr_s1 && c_ge1 && (left_q >= v_s1) && (left_q >= upleft_q)
			&& (!c_ge2 || (left_q >= left2_q));
		hit.fin   = lastr_s1 && lastc_s1 && (v_s1 >= up_s1) && (!c_ge1 || (v_s1 >= left_q));
	end

	// ---------------------------------------------------------------------------------------
	// Stage 2: output register, draining, while the sink is ready, one result request per cycle
	// ---------------------------------------------------------------------------------------
	res_mask_t           mask_s2;
	res_mask_t           rest_s2;
	logic [ROW_BITS-1:0] r_s2;
	logic [CIDX-1:0]     c_s2;
	logic                pop;
	logic                s2_free;

	assign peak_valid = (mask_s2 != '0);
	assign pop        = peak_valid && peak_ready;
	assign rest_s2    = mask_s2 & (mask_s2 - 3'd1);
	assign s2_free    = !peak_valid || (pop && rest_s2 == '0);
	assign s1_adv     = s1_valid_q && s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (s1_adv) begin
			mask_s2 <= hit;
		end else if (pop) begin
			mask_s2 <= rest_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	// The lowest pending bit is the one on show: row above first, then the last row.
	logic sel_left;

	assign sel_left    = !mask_s2.above && mask_s2.left;
	assign peak_row    = mask_s2.above ? r_s2 - ROW_BITS'(1) : r_s2;
	assign peak_col    = COL_BITS'(sel_left ? c_s2 - CIDX'(1) : c_s2);
	assign last_of_run = (rest_s2 == '0);

	// ---------------------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------------------
	`GLPF_ASSERT_NXT(a_drain_continues, pop && $countones(mask_s2) > 1, peak_valid,
		"pending result dropped while draining")
	`GLPF_ASSERT_IMP(a_last_is_single, peak_valid && last_of_run, $onehot(mask_s2),
		"last_of_run raised with further results pending")
	`GLPF_ASSERT_IMP(a_col_in_range, 1'b1, CNT_W'(col_q) < CNT_W'(MAX_COLS),
		"column counter beyond the line store")
	`GLPF_ASSERT_NXT(a_row_end_wraps, acc && lastc_in, col_q == '0,
		"column counter did not wrap at the end of a row")

endmodule

`default_nettype wire
